### src/utf8_hungarian_to_ascii_top_defines.svh
// ----------------------------------------------------------------------------
// utf8_hungarian_to_ascii_top_defines.svh
// Assertion macros shared by the transliterator modules
// ----------------------------------------------------------------------------
`ifndef UTF8_HUNGARIAN_TO_ASCII_TOP_DEFINES_SVH
`define UTF8_HUNGARIAN_TO_ASCII_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define U2A_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define U2A_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define U2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg
// Types, codes and lookup tables of the UTF-8 to ASCII transliterator
// ----------------------------------------------------------------------------
package u2a_pkg;

  localparam int PAIR_COUNT = 26;
  localparam int TEXT_LEN   = 4;

  // error codes carried on the result channel
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_BAD_EURO = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;
  localparam logic [1:0] ERR_TRUNC    = 2'd3;

  // special byte values
  localparam logic [7:0] BYTE_EURO_LEAD = 8'hE2;
  localparam logic [7:0] BYTE_EURO_MID  = 8'h82;
  localparam logic [7:0] BYTE_EURO_TAIL = 8'hAC;
  localparam logic [7:0] BYTE_DOLLAR    = 8'h24;
  localparam logic [7:0] BYTE_NUL       = 8'h00;

  // command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_USD  = 2'd1,
    CMD_EUR  = 2'd2,
    CMD_ERR  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [6:0] ch;
    logic       done;
    logic [1:0] err;
  } cmd_t;

  // front decoder state
  typedef enum logic [2:0] {
    P_IDLE = 3'b001,
    P_LEAD = 3'b010,
    P_EURO = 3'b100
  } pend_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] letter;
  } pair_hit_t;

  localparam logic [7:0] PAIR_LEAD [PAIR_COUNT] = '{
    8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC5, 8'hC3, 8'hC3, 8'hC5, 8'hC3,
    8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC5, 8'hC3, 8'hC3, 8'hC5, 8'hC5, 8'hC5,
    8'hC2, 8'hC4, 8'hC4, 8'hC5, 8'hC5, 8'hC5};

  localparam logic [7:0] PAIR_TAIL [PAIR_COUNT] = '{
    8'hA1, 8'hA9, 8'hAD, 8'hB3, 8'hB6, 8'h91, 8'hBA, 8'hBC, 8'hB1, 8'h81,
    8'h89, 8'h8D, 8'h93, 8'h96, 8'h90, 8'h9A, 8'h9C, 8'hB0, 8'hBB, 8'hBC,
    8'hB7, 8'h9F, 8'hB0, 8'h9F, 8'h9E, 8'h9B};

  localparam logic [6:0] PAIR_LETTER [PAIR_COUNT] = '{
    7'h61, 7'h65, 7'h69, 7'h6F, 7'h6F, 7'h6F, 7'h75, 7'h75, 7'h75, 7'h41,
    7'h45, 7'h49, 7'h4F, 7'h4F, 7'h4F, 7'h55, 7'h55, 7'h55, 7'h5A, 7'h7A,
    7'h7E, 7'h67, 7'h49, 7'h73, 7'h53, 7'h73};

  // two-byte pair lookup, first match wins
  function automatic pair_hit_t pair_lookup(input logic [7:0] lead,
                                            input logic [7:0] tail);
    pair_hit_t res;
    res = '0;
    for (int j = PAIR_COUNT - 1; j >= 0; j--) begin
      if (PAIR_LEAD[j] == lead && PAIR_TAIL[j] == tail) begin
        res.hit    = 1'b1;
        res.letter = PAIR_LETTER[j];
      end
    end
    return res;
  endfunction

  // characters of the four-character expansions
  function automatic logic [6:0] text_char(input cmd_kind_t kind,
                                           input logic [1:0] idx);
    logic [6:0] c;
    c = 7'h20;
    if (kind == CMD_USD) begin
      case (idx)
        2'd0:    c = 7'h55;
        2'd1:    c = 7'h53;
        2'd2:    c = 7'h44;
        default: c = 7'h20;
      endcase
    end else begin
      case (idx)
        2'd0:    c = 7'h45;
        2'd1:    c = 7'h55;
        2'd2:    c = 7'h52;
        default: c = 7'h20;
      endcase
    end
    return c;
  endfunction

endpackage

### src/u2a_front.sv
// ----------------------------------------------------------------------------
// u2a_front
// Byte classifier: tracks multi-byte sequences and issues one command per
// byte that causes output
// ----------------------------------------------------------------------------
`include "utf8_hungarian_to_ascii_top_defines.svh"

module u2a_front import u2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_text_end,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  pend_t      pend_r, pend_nxt;
  logic [7:0] lead_r, lead_nxt;
  logic       disc_r, disc_nxt;
  logic       acc;
  logic       gen;
  logic       err_hit;
  logic [1:0] err_code;
  pair_hit_t  pair;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign pair     = pair_lookup(lead_r, in_text_byte);

  // classify the incoming byte against the held sequence
  always_comb begin
    pend_nxt      = pend_r;
    lead_nxt      = lead_r;
    disc_nxt      = disc_r;
    gen           = 1'b0;
    err_hit       = 1'b0;
    err_code      = ERR_OK;
    push_cmd.kind = CMD_CHAR;
    push_cmd.ch   = 7'd0;
    push_cmd.done = in_text_end;
    push_cmd.err  = ERR_OK;
    if (disc_r) begin
      if (in_text_end) begin
        disc_nxt = 1'b0;
      end
    end else begin
      case (pend_r)
        P_EURO: begin
          pend_nxt = P_IDLE;
          lead_nxt = 8'd0;
          if (in_text_byte == BYTE_EURO_TAIL) begin
            gen           = 1'b1;
            push_cmd.kind = CMD_EUR;
          end else begin
            err_hit  = 1'b1;
            err_code = ERR_BAD_EURO;
          end
        end
        P_LEAD: begin
          if (lead_r == BYTE_EURO_LEAD && in_text_byte == BYTE_EURO_MID) begin
            if (in_text_end) begin
              err_hit  = 1'b1;
              err_code = ERR_TRUNC;
            end else begin
              pend_nxt = P_EURO;
            end
          end else if (pair.hit) begin
            pend_nxt      = P_IDLE;
            lead_nxt      = 8'd0;
            gen           = 1'b1;
            push_cmd.kind = CMD_CHAR;
            push_cmd.ch   = pair.letter;
          end else begin
            err_hit  = 1'b1;
            err_code = ERR_UNKNOWN;
          end
        end
        P_IDLE: begin
          if (in_text_byte[7]) begin
            if (in_text_end) begin
              err_hit  = 1'b1;
              err_code = ERR_TRUNC;
            end else begin
              pend_nxt = P_LEAD;
              lead_nxt = in_text_byte;
            end
          end else if (in_text_byte == BYTE_DOLLAR) begin
            gen           = 1'b1;
            push_cmd.kind = CMD_USD;
          end else if (in_text_byte != BYTE_NUL) begin
            gen           = 1'b1;
            push_cmd.kind = CMD_CHAR;
            push_cmd.ch   = in_text_byte[6:0];
          end
        end
        default: begin
          pend_nxt = P_IDLE;
          lead_nxt = 8'd0;
        end
      endcase
      // error: report once, then skip to end of text
      if (err_hit) begin
        pend_nxt      = P_IDLE;
        lead_nxt      = 8'd0;
        disc_nxt      = !in_text_end;
        gen           = 1'b1;
        push_cmd.kind = CMD_ERR;
        push_cmd.ch   = 7'd0;
        push_cmd.err  = err_code;
      end
    end
  end

  assign push = acc && gen;

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= P_IDLE;
      lead_r <= 8'd0;
      disc_r <= 1'b0;
    end else if (acc) begin
      pend_r <= pend_nxt;
      lead_r <= lead_nxt;
      disc_r <= disc_nxt;
    end
  end

  // checks
  `U2A_ASSERT_IMPLIES(a_disc_idle, disc_r, pend_r == P_IDLE, "discarding with held bytes")
  `U2A_ASSERT_IMPLIES(a_lead_high, pend_r == P_LEAD, lead_r[7], "held lead byte is not high")
  `U2A_ASSERT_IMPLIES(a_push_room, push, !q_full, "command issued into full queue")
  `U2A_ASSERT_NEXT(a_err_skip, push && push_cmd.kind == CMD_ERR && !push_cmd.done,
    disc_r, "error did not start discarding")

endmodule

### src/u2a_queue.sv
// ----------------------------------------------------------------------------
// u2a_queue
// Small command queue between classifier and expander
// ----------------------------------------------------------------------------
module u2a_queue import u2a_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic empty,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

### src/u2a_back.sv
// ----------------------------------------------------------------------------
// u2a_back
// Expander: turns queued commands into result requests, one per cycle while
// the receiver does not stall, through a registered output stage
// ----------------------------------------------------------------------------
`include "utf8_hungarian_to_ascii_top_defines.svh"

module u2a_back import u2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char,
  output logic       out_char_valid,
  output logic       out_run_last,
  output logic       out_text_done,
  output logic [1:0] out_error_code
);

  logic       out_valid_r;
  logic [6:0] char_r, char_nxt;
  logic       cval_r, cval_nxt;
  logic       last_r, last_nxt;
  logic       done_r;
  logic [1:0] err_r;
  logic [1:0] idx_r;
  logic       load;
  logic       expand;

  assign load   = !out_valid_r || !out_stall;
  assign expand = (head.kind == CMD_USD) || (head.kind == CMD_EUR);
  assign pop    = load && !q_empty && last_nxt;

  // build the result for the current sub-index of the head command
  always_comb begin
    case (head.kind)
      CMD_USD, CMD_EUR: begin
        char_nxt = text_char(head.kind, idx_r);
        cval_nxt = 1'b1;
        last_nxt = (idx_r == 2'(TEXT_LEN - 1));
      end
      CMD_ERR: begin
        char_nxt = 7'd0;
        cval_nxt = 1'b0;
        last_nxt = 1'b1;
      end
      default: begin
        char_nxt = head.ch;
        cval_nxt = 1'b1;
        last_nxt = 1'b1;
      end
    endcase
  end

  // output register and sub-index counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        idx_r <= last_nxt ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      char_r <= char_nxt;
      cval_r <= cval_nxt;
      last_r <= last_nxt;
      done_r <= head.done;
      err_r  <= head.err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = char_r;
  assign out_char_valid = cval_r;
  assign out_run_last   = last_r;
  assign out_text_done  = done_r;
  assign out_error_code = err_r;

  // checks
  `U2A_ASSERT_IMPLIES(a_err_shape, out_valid_r && err_r != ERR_OK,
    !cval_r && last_r, "error result carries a character")
  `U2A_ASSERT_IMPLIES(a_char_ok, out_valid_r && cval_r, err_r == ERR_OK,
    "character result flagged as error")
  `U2A_ASSERT_IMPLIES(a_idx_expand, idx_r != 2'd0, !q_empty && expand,
    "sub-index set without an expansion at head")
  `U2A_ASSERT_NEXT(a_mid_not_last, out_valid_r && !out_stall && !last_r,
    out_valid_r, "expansion broken off before its last character")

endmodule

### src/utf8_hungarian_to_ascii_top.sv
// ----------------------------------------------------------------------------
// utf8_hungarian_to_ascii_top
// UTF-8 to ASCII transliterator for Hungarian text with euro/dollar signs
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one text byte per request, with
//   in_text_end marking the last byte of a text. Output channel
//   (out_valid/out_stall) delivers result requests: a character or an
//   error code, with run_last on the last result of a byte and text_done
//   copied from that byte's end flag.
//   An accepted byte's command is written into the command queue, and its
//   first result is then loaded from the queue head into the output register.
//   Throughput: while the queue is not full, one byte per cycle for bytes
//   giving zero or one result; '$' and the euro sign occupy the expander for
//   four results each, and the command queue (QUEUE_DEPTH entries) absorbs
//   those bursts before in_stall rises.
//   Reset (rst_n low, synchronous) clears the held sequence, the discard
//   flag, the queue and the output register.
//   When the receiver stalls, the output register holds its result, the
//   queue fills, and in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module utf8_hungarian_to_ascii_top import u2a_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_text_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char,
  output logic       out_char_valid,
  output logic       out_run_last,
  output logic       out_text_done,
  output logic [1:0] out_error_code
);

  logic q_full, q_empty, push, pop;
  cmd_t push_cmd, head;

  // classifier
  u2a_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_text_end  (in_text_end),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // command queue
  u2a_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  // expander
  u2a_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_run_last   (out_run_last),
    .out_text_done  (out_text_done),
    .out_error_code (out_error_code)
  );

endmodule
